### rtl/mts_pkg.sv
// shared types and constants for the max tracking stack
package mts_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] max;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

### rtl/mts_cell.sv
// one stack position: takes the entry above on push and the entry below on pop
module mts_cell (
  input  logic            clk_i,
  input  mts_pkg::shift_t shift_i,
  input  mts_pkg::entry_t above_i,
  input  mts_pkg::entry_t below_i,
  output mts_pkg::entry_t entry_o
);

  mts_pkg::entry_t entry_q;
  mts_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i.push) begin
      entry_d = above_i;
    end else if (shift_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

### rtl/max_tracking_stack.sv
// top level of the max tracking stack built as a chain of shifting cells
//
// Usage: drive action_i and push_value_i with start high for one cycle. A
// command is taken at any rising edge with start high and busy low; busy is
// always low, so a new push or pop may be issued in every cycle.
// action_i low pushes push_value_i, high pops the top entry.
// In the cycle after the command transfer, strobe_o is high for exactly one
// cycle and the result ports carry popped_value_o, status_o, top_value_o,
// max_value_o, is_empty_o and entry_count_o for that command. Throughput is
// one command per cycle: every cell of the chain shifts by one position per
// successful push or pop, so the top entry and its running maximum always
// sit in the first cell.
// A push on a full stack reports overflow and a pop on an empty stack
// reports underflow; neither changes the stack.
// Reset clears the entry count and the strobe; cell contents need no reset
// since only cells below the count are ever shown.
// The receiver cannot stall: each result is transferred at the edge that
// ends its strobe cycle.
module max_tracking_stack (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   action_i,
  input  logic signed [mts_pkg::DATA_W-1:0]      push_value_i,
  output logic                                   strobe_o,
  output logic signed [mts_pkg::DATA_W-1:0]      popped_value_o,
  output logic        [1:0]                      status_o,
  output logic signed [mts_pkg::DATA_W-1:0]      top_value_o,
  output logic signed [mts_pkg::DATA_W-1:0]      max_value_o,
  output logic                                   is_empty_o,
  output logic        [mts_pkg::CNT_W-1:0]       entry_count_o
);

  localparam logic [mts_pkg::CNT_W-1:0] FullCnt = mts_pkg::CNT_W'(mts_pkg::DEPTH);

  logic                               accept;
  logic                               is_push;
  logic                               full;
  logic                               empty;
  mts_pkg::shift_t                    shift;
  mts_pkg::entry_t                    new_entry;
  mts_pkg::entry_t                    cells [mts_pkg::DEPTH];
  logic [mts_pkg::CNT_W-1:0]          count_q, count_d;
  logic                               strobe_q;
  logic signed [mts_pkg::DATA_W-1:0]  popped_q, popped_d;
  mts_pkg::status_e                   status_q, status_d;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign is_push = (mts_pkg::action_e'(action_i) == mts_pkg::ACT_PUSH);
  assign full    = (count_q == FullCnt);
  assign empty   = (count_q == '0);

  assign shift.push = accept & is_push & ~full;
  assign shift.pop  = accept & ~is_push & ~empty;

  // running maximum of the new entry against the current top
  always_comb begin
    new_entry.value = push_value_i;
    new_entry.max   = push_value_i;
    if (!empty && (cells[0].max > push_value_i)) begin
      new_entry.max = cells[0].max;
    end
  end

  for (genvar i = 0; i < mts_pkg::DEPTH; i++) begin : g_cell
    mts_pkg::entry_t above;
    mts_pkg::entry_t below;
    if (i == 0) begin : g_first
      assign above = new_entry;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == mts_pkg::DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cells[i+1];
    end
    mts_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .entry_o (cells[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = mts_pkg::STAT_OK;
    if (accept) begin
      if (is_push) begin
        if (full) begin
          status_d = mts_pkg::STAT_OVERFLOW;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status_d = mts_pkg::STAT_UNDERFLOW;
        end else begin
          count_d  = count_q - 1'b1;
          popped_d = cells[0].value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      strobe_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign strobe_o       = strobe_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign is_empty_o     = (count_q == '0);
  assign entry_count_o  = count_q;
  assign top_value_o    = is_empty_o ? '0 : cells[0].value;
  assign max_value_o    = is_empty_o ? '0 : cells[0].max;

endmodule
